>>> rtl/core/pcrs_pkg.sv
// ----------------------------------------------------------------------------
// pcrs_pkg
// Shared types and constants of the per-channel running statistics unit.
// ----------------------------------------------------------------------------
package pcrs_pkg;

	localparam int CHANNELS = 256;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};
	localparam logic [31:0]        CNT_MAX = '1;
	localparam logic [63:0]        SQ_MAX  = '1;

	typedef logic [CH_W-1:0] chan_idx_t;

	typedef struct packed {
		logic [31:0]        count;
		logic signed [31:0] min_v;
		logic signed [31:0] max_v;
		logic signed [63:0] sum;
		logic [63:0]        sq_sum;
		logic signed [31:0] last_v;
	} entry_t;

	typedef struct packed {
		logic      en;
		chan_idx_t idx;
		entry_t    entry;
	} tbl_wr_t;

	typedef struct packed {
		logic               found;
		logic [31:0]        sample_count;
		logic signed [31:0] min_value;
		logic signed [31:0] max_value;
		logic signed [63:0] running_sum;
		logic [63:0]        sum_of_squares;
		logic signed [31:0] latest_value;
	} rsp_t;

endpackage

>>> rtl/core/pcrs_if.sv
// ----------------------------------------------------------------------------
// pcrs_req_if / pcrs_rsp_if
// Valid/ready channels for requests and results of the statistics unit.
// ----------------------------------------------------------------------------
interface pcrs_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [7:0]         channel;
	logic signed [31:0] sample_value;

	modport source (output valid, req_type, channel, sample_value, input ready);
	modport sink (input valid, req_type, channel, sample_value, output ready);
endinterface

interface pcrs_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic [31:0]        sample_count;
	logic signed [31:0] min_value;
	logic signed [31:0] max_value;
	logic signed [63:0] running_sum;
	logic [63:0]        sum_of_squares;
	logic signed [31:0] latest_value;

	modport source (output valid, found, sample_count, min_value, max_value,
		running_sum, sum_of_squares, latest_value, input ready);
	modport sink (input valid, found, sample_count, min_value, max_value,
		running_sum, sum_of_squares, latest_value, output ready);
endinterface

>>> rtl/core/pcrs_table.sv
// ----------------------------------------------------------------------------
// pcrs_table
// Statistics table: one wide synchronous memory with registered read,
// write-to-read bypass, and per-entry valid bits cleared by reset.
// ----------------------------------------------------------------------------
module pcrs_table import pcrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rd_en,
	input  chan_idx_t rd_idx,
	input  tbl_wr_t   wr,
	output entry_t    rd_entry,
	output logic      rd_valid
);

	entry_t              mem [CHANNELS];
	entry_t              rd_entry_q;
	logic                rd_valid_q;
	logic [CHANNELS-1:0] valid_q;
	logic                fwd;

	// a write landing on the entry being read wins over the stale array word
	assign fwd = wr.en && (wr.idx == rd_idx);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry_q <= fwd ? wr.entry : mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= fwd ? 1'b1 : valid_q[rd_idx];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && fwd |=> rd_valid)
		else $error("bypassed read did not report a valid entry");

	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> valid_q[$past(wr.idx)])
		else $error("written entry not marked valid");

endmodule

>>> rtl/core/pcrs_fold.sv
// ----------------------------------------------------------------------------
// pcrs_fold
// Folds one sample into a table entry and forms the result beat.
// ----------------------------------------------------------------------------
module pcrs_fold import pcrs_pkg::*; (
	input  logic               req_type,
	input  logic               in_range,
	input  logic signed [31:0] sample,
	input  logic [63:0]        square,
	input  entry_t             old_entry,
	input  logic               old_valid,
	output entry_t             new_entry,
	output logic               wr_need,
	output rsp_t               result
);

	logic signed [63:0] sample_x;
	logic signed [63:0] sum_add;
	logic               sum_ovf;
	logic [64:0]        sq_add;
	entry_t             shown;

	assign sample_x = 64'(sample);
	assign sum_add  = old_entry.sum + sample_x;
	// overflow only when both operands share a sign the result lost
	assign sum_ovf  = (old_entry.sum[63] == sample[31]) && (sum_add[63] != old_entry.sum[63]);
	assign sq_add   = {1'b0, old_entry.sq_sum} + {1'b0, square};

	always_comb begin
		new_entry.last_v = sample;
		if (!old_valid) begin
			new_entry.count  = 32'd1;
			new_entry.min_v  = sample;
			new_entry.max_v  = sample;
			new_entry.sum    = sample_x;
			new_entry.sq_sum = square;
		end else begin
			new_entry.count  = (old_entry.count == CNT_MAX) ? CNT_MAX : old_entry.count + 32'd1;
			new_entry.min_v  = (sample < old_entry.min_v) ? sample : old_entry.min_v;
			new_entry.max_v  = (sample > old_entry.max_v) ? sample : old_entry.max_v;
			new_entry.sum    = sum_ovf ? (sample[31] ? SUM_MIN : SUM_MAX) : sum_add;
			new_entry.sq_sum = sq_add[64] ? SQ_MAX : sq_add[63:0];
		end
	end

	assign wr_need = in_range && (req_type == REQ_RECORD);

	always_comb begin
		result = '0;
		shown  = (req_type == REQ_RECORD) ? new_entry : old_entry;
		if (wr_need || (in_range && old_valid)) begin
			result.found          = 1'b1;
			result.sample_count   = shown.count;
			result.min_value      = shown.min_v;
			result.max_value      = shown.max_v;
			result.running_sum    = shown.sum;
			result.sum_of_squares = shown.sq_sum;
			result.latest_value   = shown.last_v;
		end
	end

endmodule

>>> rtl/core/per_channel_running_stats_unit.sv
// ----------------------------------------------------------------------------
// per_channel_running_stats_unit
// Running count, min, max, sum, sum of squares and last value per channel.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request beats (req_type 0 records sample_value into channel,
//          req_type 1 reads the channel). One result beat per request.
//   rsp  : result beats; found is 0 for an empty or out-of-range channel,
//          with all other fields 0.
// Timing: a taken request and its table read are registered together into
//   the fold stage; the fold works on that registered read, and the result
//   and the write-back land at the same edge.
// Throughput: 1 request per cycle unless rsp stalls. The table read of
//   a request overlaps the write-back of the previous one; a bypass at the
//   read register passes on the fresh entry when both hit the same channel.
// Reset: all channels read as empty right after reset; no clearing pass.
// Stall: when rsp is not taken, the output register holds, the fold stage
//   holds behind it, and req.ready drops until the stage frees up.
// ----------------------------------------------------------------------------
module per_channel_running_stats_unit import pcrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pcrs_req_if.sink   req,
	pcrs_rsp_if.source rsp
);

	logic               s1_valid_q;
	logic               req_type_s1;
	logic               in_range_s1;
	chan_idx_t          chan_s1;
	logic signed [31:0] sample_s1;
	logic [63:0]        sq_s1;
	logic signed [63:0] product;

	logic    accept;
	logic    finish;
	logic    in_range;
	entry_t  rd_entry;
	logic    rd_valid;
	entry_t  new_entry;
	logic    wr_need;
	rsp_t    result;
	tbl_wr_t wr;

	logic out_valid_q;
	rsp_t rsp_q;

	assign in_range = 32'(req.channel) < CHANNELS;
	assign product  = req.sample_value * req.sample_value;

	assign finish    = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || finish;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (finish) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			in_range_s1 <= in_range;
			chan_s1     <= CH_W'(req.channel);
			sample_s1   <= req.sample_value;
			sq_s1       <= product;
		end
	end

	assign wr.en    = finish && wr_need;
	assign wr.idx   = chan_s1;
	assign wr.entry = new_entry;

	pcrs_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx   (CH_W'(req.channel)),
		.wr       (wr),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid)
	);

	pcrs_fold u_fold (
		.req_type  (req_type_s1),
		.in_range  (in_range_s1),
		.sample    (sample_s1),
		.square    (sq_s1),
		.old_entry (rd_entry),
		.old_valid (rd_valid),
		.new_entry (new_entry),
		.wr_need   (wr_need),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.found          = rsp_q.found;
	assign rsp.sample_count   = rsp_q.sample_count;
	assign rsp.min_value      = rsp_q.min_value;
	assign rsp.max_value      = rsp_q.max_value;
	assign rsp.running_sum    = rsp_q.running_sum;
	assign rsp.sum_of_squares = rsp_q.sum_of_squares;
	assign rsp.latest_value   = rsp_q.latest_value;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !finish |=> s1_valid_q && $stable(chan_s1) && $stable(sample_s1))
		else $error("fold stage lost its beat while stalled");

	a_wr_in_s1: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> s1_valid_q && in_range_s1 && (req_type_s1 == REQ_RECORD))
		else $error("table write without a record in the fold stage");

	a_record_found: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> rsp.valid && rsp.found && (rsp.sample_count != 32'd0))
		else $error("recorded sample not reported as found");

endmodule

>>> tb/sv/pcrs_stats_checker.sv
// ----------------------------------------------------------------------------
// pcrs_stats_checker
// Watches the request and result channels of the statistics unit. It keeps
// its own copy of the per-channel table, works out the result of every
// request beat and compares each result beat, field by field, with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
module pcrs_stats_checker import pcrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pcrs_req_if         req,
	pcrs_rsp_if         rsp,
	output int unsigned fail_count,
	output int unsigned outstanding
);

	localparam int unsigned DUE_DEPTH = 16;

	entry_t      stats [CHANNELS];
	rsp_t        due [DUE_DEPTH];
	logic [3:0]  due_wr;
	logic [3:0]  due_rd;
	int unsigned pending;
	rsp_t        want;
	int unsigned fails;

	// Fold one request into the local table and return the result it causes.
	function automatic rsp_t fold_request(logic kind, logic [7:0] ch,
		logic signed [31:0] v);
		rsp_t               res;
		entry_t             e;
		logic signed [63:0] wide;
		logic [63:0]        square;
		logic signed [64:0] sum_x;
		logic [64:0]        sq_x;
		res = '0;
		if (ch >= CHANNELS)
			return res;
		e = stats[ch];
		if (kind == REQ_RECORD) begin
			wide   = v;
			square = wide * wide;
			if (e.count == '0) begin
				e.min_v  = v;
				e.max_v  = v;
				e.sum    = wide;
				e.sq_sum = square;
			end else begin
				if (v < e.min_v)
					e.min_v = v;
				if (v > e.max_v)
					e.max_v = v;
				sum_x = e.sum + wide;
				if (sum_x[64] != sum_x[63])
					e.sum = sum_x[64] ? SUM_MIN : SUM_MAX;
				else
					e.sum = sum_x[63:0];
				sq_x = {1'b0, e.sq_sum} + {1'b0, square};
				e.sq_sum = sq_x[64] ? SQ_MAX : sq_x[63:0];
			end
			// count sticks at its maximum, the rest keeps folding
			if (e.count != CNT_MAX)
				e.count = e.count + 32'd1;
			e.last_v = v;
			stats[ch] = e;
		end else if (e.count == '0) begin
			return res;
		end
		res.found          = 1'b1;
		res.sample_count   = e.count;
		res.min_value      = e.min_v;
		res.max_value      = e.max_v;
		res.running_sum    = e.sum;
		res.sum_of_squares = e.sq_sum;
		res.latest_value   = e.last_v;
		return res;
	endfunction

	function automatic int field_diff(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++)
				stats[i] = '0;
			due_wr = '0;
			due_rd = '0;
			pending = 0;
			fails = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready) begin
				if (pending == DUE_DEPTH) begin
					$display("%0t: more requests outstanding than the checker holds", $time);
					fails++;
				end
				due[due_wr] = fold_request(req.req_type, req.channel, req.sample_value);
				due_wr = due_wr + 4'd1;
				pending++;
			end
			if (rsp.valid && rsp.ready) begin
				if (pending == 0) begin
					$display("%0t: result beat with no request outstanding", $time);
					fails++;
				end else begin
					want = due[due_rd];
					due_rd = due_rd + 4'd1;
					pending--;
					fails += field_diff("found", 64'(want.found), 64'(rsp.found));
					fails += field_diff("sample_count", 64'(want.sample_count),
						64'(rsp.sample_count));
					fails += field_diff("min_value", 64'(want.min_value),
						64'(rsp.min_value));
					fails += field_diff("max_value", 64'(want.max_value),
						64'(rsp.max_value));
					fails += field_diff("running_sum", want.running_sum, rsp.running_sum);
					fails += field_diff("sum_of_squares", want.sum_of_squares,
						rsp.sum_of_squares);
					fails += field_diff("latest_value", 64'(want.latest_value),
						64'(rsp.latest_value));
				end
			end
			fail_count <= fails;
			outstanding <= pending;
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives record and read beats into the statistics unit with random gaps
// on the request side and random stalls on the result side, including one
// long result stall that backs the unit up. A checker beside the unit
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import pcrs_pkg::*; ();

	localparam int unsigned RANDOM_ITEMS   = 1800;
	localparam int unsigned QUIET_FROM     = RANDOM_ITEMS - 180;
	localparam int unsigned HOLD_AT        = 700;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;

	logic        clk;
	logic        arst_n;
	int unsigned sent_count;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned quiet_cycles;
	bit          long_hold_done;

	pcrs_req_if req_ch ();
	pcrs_rsp_if rsp_ch ();

	per_channel_running_stats_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pcrs_stats_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit sender_may_idle();
		if (sent_count >= QUIET_FROM)
			return 1'b0;
		// keep offering beats while the long result stall is on
		if (sent_count >= HOLD_AT && sent_count < HOLD_AT + 100)
			return 1'b0;
		return (sent_count / 150) % 3 != 2;
	endfunction

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom_range(0, 2000) - 1000;
			3, 4: return $urandom_range(0, 200000) - 100000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [7:0] pick_channel();
		int unsigned hot;
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		// a few hot channels at both ends of the table, so entries repeat
		hot = $urandom_range(0, 7);
		return (hot < 4) ? 8'(hot) : 8'(248 + hot);
	endfunction

	task automatic send_req(logic kind, logic [7:0] ch, logic signed [31:0] v);
		int unsigned gap;
		if (sender_may_idle() && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.channel      <= ch;
		req_ch.sample_value <= v;
		do @(posedge clk); while (!req_ch.ready);
		sent_count++;
	endtask

	// result side: random stall bursts, one long hold, none near the end
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!long_hold_done && sent_count >= HOLD_AT) begin
				long_hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (sent_count < QUIET_FROM && (sent_count / 110) % 3 != 1
				&& $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic kind;
		sent_count   = 0;
		req_ch.valid        <= 1'b0;
		req_ch.req_type     <= REQ_RECORD;
		req_ch.channel      <= '0;
		req_ch.sample_value <= '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty channel, then its first sample
		send_req(REQ_READ, 8'd0, 32'sd0);
		send_req(REQ_RECORD, 8'd0, 32'sd0);
		send_req(REQ_READ, 8'd0, 32'sd0);
		// field extremes on the last channel
		send_req(REQ_RECORD, 8'd255, 32'sh7FFF_FFFF);
		send_req(REQ_RECORD, 8'd255, 32'sh8000_0000);
		send_req(REQ_RECORD, 8'd255, -32'sd1);
		send_req(REQ_READ, 8'd255, 32'sh7FFF_FFFF);
		// drive the sum of squares into saturation
		repeat (5) send_req(REQ_RECORD, 8'd1, 32'sh8000_0000);
		send_req(REQ_READ, 8'd1, -32'sd1);
		// same channel in a row, through the bypass when no gap falls between
		send_req(REQ_RECORD, 8'd2, 32'sd1);
		send_req(REQ_RECORD, 8'd2, -32'sd1);
		send_req(REQ_RECORD, 8'd2, 32'sd5);
		send_req(REQ_READ, 8'd2, 32'sd0);
		// alternating bit patterns
		send_req(REQ_RECORD, 8'hAA, 32'sh5555_5555);
		send_req(REQ_RECORD, 8'h55, 32'shAAAA_AAAA);
		send_req(REQ_READ, 8'hAA, 32'sh1234_5678);
		send_req(REQ_READ, 8'd128, -32'sd1);
		send_req(REQ_READ, 8'd3, 32'sh1234_5678);

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			kind = ($urandom_range(0, 3) == 0) ? REQ_READ : REQ_RECORD;
			send_req(kind, pick_channel(), (kind == REQ_READ) ? $urandom() : pick_sample());
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/pcrs_pkg.sv
rtl/core/pcrs_if.sv
rtl/core/pcrs_table.sv
rtl/core/pcrs_fold.sv
rtl/core/per_channel_running_stats_unit.sv
tb/sv/pcrs_stats_checker.sv
tb/sv/tb_top.sv
